// ===== rtl/core/sgdfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdfu_pkg
// Shared constants, codes and controller/datapath interface types for the
// latent factor update block.
// ----------------------------------------------------------------------------
package sgdfu_pkg;

   localparam int LATENT     = 20;
   localparam int ITEM_ROWS  = 1024;
   localparam int USER_ROWS  = 1024;
   localparam int ITEM_DEPTH = ITEM_ROWS * LATENT;
   localparam int USER_DEPTH = USER_ROWS * LATENT;
   localparam int IADDR_W    = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
   localparam int UADDR_W    = (USER_DEPTH > 1) ? $clog2(USER_DEPTH) : 1;
   localparam int K_W        = (LATENT > 1) ? $clog2(LATENT) : 1;

   localparam int ACT_W      = 2;
   localparam int ROW_W      = 10;
   localparam int ELEM_W     = 5;
   localparam int VAL_W      = 32;
   localparam int RATING_W   = 8;
   localparam int ERR_W      = 40;
   localparam int FRAC_W     = 24;
   localparam int CFG_W      = 32;
   localparam int CSR_IDX_W  = 1;

   localparam int ACC_W      = 2 * VAL_W - FRAC_W + K_W + 1;
   localparam int ERRR_W     = ACC_W + 2;
   localparam int GRAD_W     = 49;
   localparam int NEW_W      = 52;

   localparam logic [CFG_W-1:0] STEP_RESET   = 32'd4294967;
   localparam logic [CFG_W-1:0] LAMBDA_RESET = 32'd4294967;

   localparam logic [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
   localparam logic [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_STEP   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAMBDA = 1'd1;

   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_TRAIN = 2'd2
   } act_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ACCESS,
      ST_DOT,
      ST_DOT_WAIT,
      ST_ERROR,
      ST_UPDATE,
      ST_UPD_WAIT
   } state_type;

   typedef struct packed {
      logic           capture;
      logic           access;
      logic           issue;
      logic           upd_mode;
      logic           last;
      logic [K_W-1:0] elem;
      logic           calc_err;
      logic           load_rsp;
   } cmd_type;

   typedef struct packed {
      logic op_access;
      logic op_train;
      logic dot_done;
      logic upd_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/sgdfu_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdfu_lane
// Registered update pipe for one vector element:
// own + step * (err * other - lambda * own), saturated to Q8.24.
// ----------------------------------------------------------------------------
module sgdfu_lane (
   input  logic                                  clock,
   input  logic signed [sgdfu_pkg::VAL_W-1:0]    own,
   input  logic signed [sgdfu_pkg::VAL_W-1:0]    other,
   input  logic signed [sgdfu_pkg::ERR_W-1:0]    err,
   input  logic        [sgdfu_pkg::CFG_W-1:0]    lambda,
   input  logic        [sgdfu_pkg::CFG_W-1:0]    step,
   output logic signed [sgdfu_pkg::VAL_W-1:0]    new_value,
   output logic                                  clipped
);

   localparam int GW = sgdfu_pkg::GRAD_W;
   localparam int NW = sgdfu_pkg::NEW_W;

   logic signed [56:0]   pa_ff, pa_in;
   logic signed [47:0]   pb_ff, pb_in;
   logic signed [64:0]   pc_ff, pc_in;
   logic signed [31:0]   own1_ff, own2_ff, own3_ff;
   logic signed [GW-1:0] grad_ff, grad_in;
   logic signed [57:0]   qh_ff, qh_in;
   logic        [55:0]   ql_ff, ql_in;
   logic signed [82:0]   total;
   logic signed [50:0]   delta;
   logic signed [NW-1:0] sum;
   logic [NW-sgdfu_pkg::VAL_W:0] hi;

   always_comb begin
      pa_in   = $signed({1'b0, err[23:0]}) * other;
      pb_in   = $signed(err[39:24]) * other;
      pc_in   = $signed({1'b0, lambda}) * own;
      grad_in = GW'(pb_ff) + GW'(pa_ff >>> 24) - GW'(pc_ff >>> 32);
      qh_in   = $signed({1'b0, step}) * $signed(grad_ff[GW-1:24]);
      ql_in   = step * grad_ff[23:0];
   end

   always_ff @(posedge clock) begin
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      pc_ff   <= pc_in;
      own1_ff <= own;
      grad_ff <= grad_in;
      own2_ff <= own1_ff;
      qh_ff   <= qh_in;
      ql_ff   <= ql_in;
      own3_ff <= own2_ff;
   end

   always_comb begin
      total   = (83'(qh_ff) <<< 24) + $signed({27'd0, ql_ff});
      delta   = 51'(total >>> 32);
      sum     = NW'(own3_ff) + NW'(delta);
      hi      = sum[NW-1:sgdfu_pkg::VAL_W-1];
      clipped = !((&hi) || !(|hi));
      if (!clipped) begin
         new_value = sum[sgdfu_pkg::VAL_W-1:0];
      end else if (sum[NW-1]) begin
         new_value = sgdfu_pkg::VAL_MIN;
      end else begin
         new_value = sgdfu_pkg::VAL_MAX;
      end
   end

endmodule

// ===== rtl/core/sgdfu_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdfu_dpath
// Vector tables, dot-product accumulator, error clip, two update lanes,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module sgdfu_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sgdfu_pkg::cmd_type                     cmd,
   output sgdfu_pkg::status_type                  status,
   input  logic [sgdfu_pkg::ACT_W-1:0]            req_action,
   input  logic                                   req_is_user,
   input  logic [sgdfu_pkg::ROW_W-1:0]            req_item_index,
   input  logic [sgdfu_pkg::ROW_W-1:0]            req_user_index,
   input  logic [sgdfu_pkg::ELEM_W-1:0]           req_element_index,
   input  logic signed [sgdfu_pkg::VAL_W-1:0]     req_element_value,
   input  logic [sgdfu_pkg::RATING_W-1:0]         req_rating,
   input  logic                                   csr_write_en,
   input  logic [sgdfu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sgdfu_pkg::CFG_W-1:0]            csr_write_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sgdfu_pkg::ERR_W-1:0]     rsp_train_error,
   output logic signed [sgdfu_pkg::VAL_W-1:0]     rsp_read_value,
   output logic                                   rsp_saturated
);

   localparam int IAW = sgdfu_pkg::IADDR_W;
   localparam int UAW = sgdfu_pkg::UADDR_W;
   localparam int KW  = sgdfu_pkg::K_W;
   localparam int AW  = sgdfu_pkg::ACC_W;
   localparam int RW  = sgdfu_pkg::ERRR_W;
   localparam int EW  = sgdfu_pkg::ERR_W;

   logic signed [31:0] item_mem [sgdfu_pkg::ITEM_DEPTH];
   logic signed [31:0] user_mem [sgdfu_pkg::USER_DEPTH];

   logic [sgdfu_pkg::CFG_W-1:0] step_ff, lambda_ff;

   logic [sgdfu_pkg::ACT_W-1:0]    act_ff;
   logic                           is_user_ff, irow_ok_ff, urow_ok_ff, elem_ok_ff;
   logic [IAW-1:0]                 ibase_ff;
   logic [UAW-1:0]                 ubase_ff;
   logic [sgdfu_pkg::ELEM_W-1:0]   elem_ff;
   logic signed [31:0]             value_ff;
   logic [sgdfu_pkg::RATING_W-1:0] rating_ff;

   logic signed [31:0] iq_ff, uq_ff;
   logic               is_read, is_write, acc_ok, read_ok;
   logic               i_rd, u_rd, i_wr, u_wr;
   logic [IAW-1:0]     i_raddr, i_waddr;
   logic [UAW-1:0]     u_raddr, u_waddr;
   logic signed [31:0] i_wdata, u_wdata;

   logic          dv1_ff, dv2_ff, dl1_ff, dl2_ff;
   logic          uv1_ff, uv2_ff, uv3_ff, uv4_ff;
   logic          ul1_ff, ul2_ff, ul3_ff, ul4_ff;
   logic [KW-1:0] ue1_ff, ue2_ff, ue3_ff, ue4_ff;

   logic signed [63:0]   prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [RW-1:0] err_raw;
   logic [RW-EW:0]       err_hi;
   logic                 err_clip;
   logic signed [EW-1:0] err_ff, err_in;
   logic                 sat_ff;

   logic signed [31:0] m_new, u_new;
   logic               m_clip, u_clip;

   logic                  rsp_valid_ff;
   logic signed [EW-1:0]  rsp_err_ff;
   logic signed [31:0]    rsp_rd_ff;
   logic                  rsp_sat_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= sgdfu_pkg::STEP_RESET;
         lambda_ff <= sgdfu_pkg::LAMBDA_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            sgdfu_pkg::CSR_STEP:   step_ff   <= csr_write_data;
            sgdfu_pkg::CSR_LAMBDA: lambda_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff     <= req_action;
         is_user_ff <= req_is_user;
         irow_ok_ff <= 32'(req_item_index) < 32'(sgdfu_pkg::ITEM_ROWS);
         urow_ok_ff <= 32'(req_user_index) < 32'(sgdfu_pkg::USER_ROWS);
         elem_ok_ff <= 32'(req_element_index) < 32'(sgdfu_pkg::LATENT);
         ibase_ff   <= IAW'(IAW'(req_item_index) * IAW'(sgdfu_pkg::LATENT));
         ubase_ff   <= UAW'(UAW'(req_user_index) * UAW'(sgdfu_pkg::LATENT));
         elem_ff    <= req_element_index;
         value_ff   <= req_element_value;
         rating_ff  <= req_rating;
      end
   end

   always_comb begin
      is_read  = act_ff == sgdfu_pkg::ACT_READ;
      is_write = act_ff == sgdfu_pkg::ACT_WRITE;
      acc_ok   = elem_ok_ff && (is_user_ff ? urow_ok_ff : irow_ok_ff);
      read_ok  = is_read && acc_ok;
      status.op_access = is_read || is_write;
      status.op_train  = (act_ff == sgdfu_pkg::ACT_TRAIN) && irow_ok_ff && urow_ok_ff;
      status.dot_done  = dv2_ff && dl2_ff;
      status.upd_done  = uv4_ff && ul4_ff;
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // memory ports
   always_comb begin
      i_rd    = cmd.issue || (cmd.access && read_ok && !is_user_ff);
      u_rd    = cmd.issue || (cmd.access && read_ok && is_user_ff);
      i_raddr = cmd.access ? ibase_ff + IAW'(elem_ff) : ibase_ff + IAW'(cmd.elem);
      u_raddr = cmd.access ? ubase_ff + UAW'(elem_ff) : ubase_ff + UAW'(cmd.elem);
      if (cmd.access) begin
         i_wr    = is_write && acc_ok && !is_user_ff;
         u_wr    = is_write && acc_ok && is_user_ff;
         i_waddr = ibase_ff + IAW'(elem_ff);
         u_waddr = ubase_ff + UAW'(elem_ff);
         i_wdata = value_ff;
         u_wdata = value_ff;
      end else begin
         i_wr    = uv4_ff;
         u_wr    = uv4_ff;
         i_waddr = ibase_ff + IAW'(ue4_ff);
         u_waddr = ubase_ff + UAW'(ue4_ff);
         i_wdata = m_new;
         u_wdata = u_new;
      end
   end

   always_ff @(posedge clock) begin
      if (i_wr) begin
         item_mem[i_waddr] <= i_wdata;
      end
      if (i_rd) begin
         iq_ff <= item_mem[i_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (u_wr) begin
         user_mem[u_waddr] <= u_wdata;
      end
      if (u_rd) begin
         uq_ff <= user_mem[u_raddr];
      end
   end

   // element pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         dv1_ff <= 1'b0;
         dv2_ff <= 1'b0;
         uv1_ff <= 1'b0;
         uv2_ff <= 1'b0;
         uv3_ff <= 1'b0;
         uv4_ff <= 1'b0;
      end else begin
         dv1_ff <= cmd.issue && !cmd.upd_mode;
         dv2_ff <= dv1_ff;
         uv1_ff <= cmd.issue && cmd.upd_mode;
         uv2_ff <= uv1_ff;
         uv3_ff <= uv2_ff;
         uv4_ff <= uv3_ff;
      end
   end

   always_ff @(posedge clock) begin
      dl1_ff <= cmd.last;
      dl2_ff <= dl1_ff;
      ul1_ff <= cmd.last;
      ul2_ff <= ul1_ff;
      ul3_ff <= ul2_ff;
      ul4_ff <= ul3_ff;
      ue1_ff <= cmd.elem;
      ue2_ff <= ue1_ff;
      ue3_ff <= ue2_ff;
      ue4_ff <= ue3_ff;
   end

   // dot product and error
   always_comb begin
      err_raw  = RW'($signed({1'b0, rating_ff, 24'd0})) - RW'(acc_ff);
      err_hi   = err_raw[RW-1:EW-1];
      err_clip = !((&err_hi) || !(|err_hi));
      if (!err_clip) begin
         err_in = err_raw[EW-1:0];
      end else if (err_raw[RW-1]) begin
         err_in = sgdfu_pkg::ERR_MIN;
      end else begin
         err_in = sgdfu_pkg::ERR_MAX;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= iq_ff * uq_ff;
      if (cmd.capture) begin
         acc_ff <= '0;
      end else if (dv2_ff) begin
         acc_ff <= acc_ff + AW'(prod_ff >>> 24);
      end
      if (cmd.calc_err) begin
         err_ff <= err_in;
      end
      if (cmd.capture) begin
         sat_ff <= 1'b0;
      end else if (cmd.calc_err && err_clip) begin
         sat_ff <= 1'b1;
      end else if (uv4_ff && (m_clip || u_clip)) begin
         sat_ff <= 1'b1;
      end
   end

   sgdfu_lane u_item_lane (
      .clock     (clock),
      .own       (iq_ff),
      .other     (uq_ff),
      .err       (err_ff),
      .lambda    (lambda_ff),
      .step      (step_ff),
      .new_value (m_new),
      .clipped   (m_clip)
   );

   sgdfu_lane u_user_lane (
      .clock     (clock),
      .own       (uq_ff),
      .other     (iq_ff),
      .err       (err_ff),
      .lambda    (lambda_ff),
      .step      (step_ff),
      .new_value (u_new),
      .clipped   (u_clip)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_err_ff <= status.op_train ? err_ff : '0;
         rsp_rd_ff  <= read_ok ? (is_user_ff ? uq_ff : iq_ff) : '0;
         rsp_sat_ff <= status.op_train && sat_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_train_error = rsp_err_ff;
   assign rsp_read_value  = rsp_rd_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

// ===== rtl/core/sgdfu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgdfu_ctrl
// Sequencer: decodes the captured request, walks the element counter through
// the dot-product and update passes, and hands the result to the output.
// ----------------------------------------------------------------------------
module sgdfu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sgdfu_pkg::status_type status,
   output sgdfu_pkg::cmd_type    cmd
);

   localparam int KW = sgdfu_pkg::K_W;

   sgdfu_pkg::state_type state_ff, state_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 k_last;

   assign k_last = k_ff == KW'(sgdfu_pkg::LATENT - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgdfu_pkg::ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      case (state_ff)
         sgdfu_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sgdfu_pkg::ST_DECODE;
            end
         end
         sgdfu_pkg::ST_DECODE: begin
            k_in = '0;
            if (status.op_access) begin
               state_in = sgdfu_pkg::ST_ACCESS;
            end else if (status.op_train) begin
               state_in = sgdfu_pkg::ST_DOT;
            end else begin
               state_in = sgdfu_pkg::ST_ACCESS;
            end
         end
         sgdfu_pkg::ST_ACCESS: begin
            if (status.out_free) begin
               state_in = sgdfu_pkg::ST_IDLE;
            end
         end
         sgdfu_pkg::ST_DOT: begin
            k_in = k_last ? '0 : k_ff + 1'b1;
            if (k_last) begin
               state_in = sgdfu_pkg::ST_DOT_WAIT;
            end
         end
         sgdfu_pkg::ST_DOT_WAIT: begin
            if (status.dot_done) begin
               state_in = sgdfu_pkg::ST_ERROR;
            end
         end
         sgdfu_pkg::ST_ERROR: begin
            state_in = sgdfu_pkg::ST_UPDATE;
         end
         sgdfu_pkg::ST_UPDATE: begin
            k_in = k_last ? '0 : k_ff + 1'b1;
            if (k_last) begin
               state_in = sgdfu_pkg::ST_UPD_WAIT;
            end
         end
         sgdfu_pkg::ST_UPD_WAIT: begin
            if (status.upd_done) begin
               state_in = sgdfu_pkg::ST_ACCESS;
            end
         end
         default: begin
            state_in = sgdfu_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.elem  = k_ff;
      cmd.last  = k_last;
      req_stall = state_ff != sgdfu_pkg::ST_IDLE;
      case (state_ff)
         sgdfu_pkg::ST_IDLE: begin
            cmd.capture = req_valid;
         end
         sgdfu_pkg::ST_DECODE: begin
            cmd.access = status.op_access;
         end
         sgdfu_pkg::ST_ACCESS: begin
            cmd.load_rsp = status.out_free;
         end
         sgdfu_pkg::ST_DOT: begin
            cmd.issue = 1'b1;
         end
         sgdfu_pkg::ST_ERROR: begin
            cmd.calc_err = 1'b1;
         end
         sgdfu_pkg::ST_UPDATE: begin
            cmd.issue    = 1'b1;
            cmd.upd_mode = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/core/sgd_factor_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_factor_update
// One stochastic-gradient step of matrix factorization over item and user
// latent vector tables in signed Q8.24, plus element read and write.
// ----------------------------------------------------------------------------
// Sequence: the request is decoded; read and write access the table, train
//   runs the dot pass, the error step and the update pass, one element per
//   cycle per table read port in each pass, plus pipe fill/drain; the result
//   loads once the output is free.
// Throughput: one item at a time; the next may transfer the cycle after the load.
// Reset: synchronous; clears control and restores step and lambda, not tables.
// ----------------------------------------------------------------------------
module sgd_factor_update (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [sgdfu_pkg::ACT_W-1:0]            req_action,
   input  logic                                   req_is_user,
   input  logic [sgdfu_pkg::ROW_W-1:0]            req_item_index,
   input  logic [sgdfu_pkg::ROW_W-1:0]            req_user_index,
   input  logic [sgdfu_pkg::ELEM_W-1:0]           req_element_index,
   input  logic signed [sgdfu_pkg::VAL_W-1:0]     req_element_value,
   input  logic [sgdfu_pkg::RATING_W-1:0]         req_rating,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [sgdfu_pkg::ERR_W-1:0]     rsp_train_error,
   output logic signed [sgdfu_pkg::VAL_W-1:0]     rsp_read_value,
   output logic                                   rsp_saturated,
   input  logic                                   csr_write_en,
   input  logic [sgdfu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sgdfu_pkg::CFG_W-1:0]            csr_write_data
);

   sgdfu_pkg::cmd_type    cmd;
   sgdfu_pkg::status_type status;

   sgdfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sgdfu_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_is_user       (req_is_user),
      .req_item_index    (req_item_index),
      .req_user_index    (req_user_index),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_rating        (req_rating),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_train_error   (rsp_train_error),
      .rsp_read_value    (rsp_read_value),
      .rsp_saturated     (rsp_saturated)
   );

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request transfer did not make the block busy");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.out_free)
      else $error("result loaded over a pending result");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("loaded result not presented");

   a_done_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(status.dot_done && status.upd_done))
      else $error("dot and update passes overlap");

endmodule
